FILE: src/history_stack_with_save_queue_assert.svh
// Assertion macros for the history stack with save queue.
`ifndef HISTORY_STACK_WITH_SAVE_QUEUE_ASSERT_SVH
`define HISTORY_STACK_WITH_SAVE_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define HSQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define HSQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`else

`define HSQ_ASSERT_SAME(label, clk, rst, ante, cons)
`define HSQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: src/hsq_pkg.sv
// Shared types and constants for the history stack with save queue.
package hsq_pkg;

   localparam int OP_W       = 3;
   localparam int PAGE_TAG_W = 32;
   localparam int COUNT_W    = 7;

   typedef enum logic [OP_W-1:0] {
      OP_OPEN   = 3'd0,
      OP_BACK   = 3'd1,
      OP_CURSOR = 3'd2,
      OP_PANIC  = 3'd3,
      OP_SAVE   = 3'd4,
      OP_READ   = 3'd5
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]       op;
      logic [PAGE_TAG_W-1:0] page_tag;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]    count;
      logic [PAGE_TAG_W-1:0] tag_out;
      logic                  tag_present;
      logic                  overflow;
   } rsp_type;

endpackage

FILE: src/hsq_channels.sv
// Request and response channel interfaces with valid/ready handshake.
interface hsq_req_if;
   logic             valid;
   logic             ready;
   hsq_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface hsq_rsp_if;
   logic             valid;
   logic             ready;
   hsq_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: src/history_stack_with_save_queue.sv
// A request is accepted in idle; its response is registered when execute commits.
// A new request is taken only after the current one commits; accepting reads the
// stack entry and queue front into registers, execute updates state and writes back.
// A response still waiting on the output stalls only the commit of a next response.
// Reset (synchronous): stack depth, queue pointers and count and the response valid
// clear at once; memory contents stay undefined, no clearing pass.
`include "history_stack_with_save_queue_assert.svh"

module history_stack_with_save_queue #(
   parameter int STACK_DEPTH = 64,
   parameter int QUEUE_DEPTH = 64,
   parameter int TAG_WIDTH   = 32
) (
   input  logic       clock,
   input  logic       reset,
   hsq_req_if.sink    req_ch,
   hsq_rsp_if.source  rsp_ch
);

   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int SDW = $clog2(STACK_DEPTH + 1);
   localparam int QAW = $clog2(QUEUE_DEPTH);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam int TIW = (TAG_WIDTH < hsq_pkg::PAGE_TAG_W) ? TAG_WIDTH : hsq_pkg::PAGE_TAG_W;

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type        state_ff, state_in;
   logic [SDW-1:0]   sdepth_ff, sdepth_in;
   logic [QAW-1:0]   qhead_ff, qhead_in;
   logic [QAW-1:0]   qtail_ff, qtail_in;
   logic [QCW-1:0]   qcount_ff, qcount_in;
   logic             rsp_valid_ff, rsp_valid_in;
   hsq_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [hsq_pkg::OP_W-1:0] op_ff;
   logic [TAG_WIDTH-1:0]     tag_ff;

   logic [TAG_WIDTH-1:0] stack_mem [STACK_DEPTH];
   logic [TAG_WIDTH-1:0] queue_mem [QUEUE_DEPTH];
   logic [TAG_WIDTH-1:0] stack_rd_ff;
   logic [TAG_WIDTH-1:0] queue_rd_ff;

   logic           accept;
   logic           commit;
   logic           has_rsp;
   logic           stack_we;
   logic           queue_we;
   logic [SAW-1:0] stack_rd_addr;
   logic           stack_full;
   logic           stack_empty;
   logic           queue_full;
   logic           queue_empty;
   logic [QAW-1:0] qhead_next;
   logic [QAW-1:0] qtail_next;

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign accept         = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   assign stack_full  = (sdepth_ff == SDW'(STACK_DEPTH));
   assign stack_empty = (sdepth_ff == '0);
   assign queue_full  = (qcount_ff == QCW'(QUEUE_DEPTH));
   assign queue_empty = (qcount_ff == '0);
   assign qhead_next  = (qhead_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : qhead_ff + QAW'(1);
   assign qtail_next  = (qtail_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : qtail_ff + QAW'(1);

   // Back needs the entry below the top; everything else needs the top.
   always_comb begin
      if (req_ch.payload.op == hsq_pkg::OP_BACK) begin
         stack_rd_addr = SAW'(sdepth_ff - SDW'(2));
      end else begin
         stack_rd_addr = SAW'(sdepth_ff - SDW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_ch.payload.op;
         tag_ff <= TAG_WIDTH'(req_ch.payload.page_tag[TIW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[sdepth_ff[SAW-1:0]] <= tag_ff;
      end
      if (accept) begin
         stack_rd_ff <= stack_mem[stack_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (queue_we) begin
         queue_mem[qtail_ff] <= stack_rd_ff;
      end
      if (accept) begin
         queue_rd_ff <= queue_mem[qhead_ff];
      end
   end

   always_comb begin
      has_rsp     = 1'b1;
      stack_we    = 1'b0;
      queue_we    = 1'b0;
      sdepth_in   = sdepth_ff;
      qhead_in    = qhead_ff;
      qtail_in    = qtail_ff;
      qcount_in   = qcount_ff;
      rsp_data_in = '0;

      unique case (op_ff)
         hsq_pkg::OP_OPEN: begin
            if (stack_full) begin
               rsp_data_in.count    = hsq_pkg::COUNT_W'(sdepth_ff);
               rsp_data_in.overflow = 1'b1;
            end else begin
               stack_we          = 1'b1;
               sdepth_in         = sdepth_ff + SDW'(1);
               rsp_data_in.count = hsq_pkg::COUNT_W'(sdepth_in);
            end
         end
         hsq_pkg::OP_BACK: begin
            if (!stack_empty) begin
               sdepth_in = sdepth_ff - SDW'(1);
               if (sdepth_in != '0) begin
                  rsp_data_in.count       = hsq_pkg::COUNT_W'(sdepth_in);
                  rsp_data_in.tag_out     = hsq_pkg::PAGE_TAG_W'(stack_rd_ff[TIW-1:0]);
                  rsp_data_in.tag_present = 1'b1;
               end
            end
         end
         hsq_pkg::OP_CURSOR: begin
            if (!stack_empty) begin
               rsp_data_in.count       = hsq_pkg::COUNT_W'(sdepth_ff);
               rsp_data_in.tag_out     = hsq_pkg::PAGE_TAG_W'(stack_rd_ff[TIW-1:0]);
               rsp_data_in.tag_present = 1'b1;
            end
         end
         hsq_pkg::OP_PANIC: begin
            sdepth_in         = '0;
            rsp_data_in.count = hsq_pkg::COUNT_W'(sdepth_ff);
         end
         hsq_pkg::OP_SAVE: begin
            if (stack_empty) begin
               has_rsp = 1'b0;
            end else if (queue_full) begin
               rsp_data_in.count    = hsq_pkg::COUNT_W'(qcount_ff);
               rsp_data_in.overflow = 1'b1;
            end else begin
               queue_we          = 1'b1;
               qtail_in          = qtail_next;
               qcount_in         = qcount_ff + QCW'(1);
               rsp_data_in.count = hsq_pkg::COUNT_W'(qcount_in);
            end
         end
         hsq_pkg::OP_READ: begin
            if (!queue_empty) begin
               qhead_in                = qhead_next;
               qcount_in               = qcount_ff - QCW'(1);
               rsp_data_in.count       = hsq_pkg::COUNT_W'(qcount_in);
               rsp_data_in.tag_out     = hsq_pkg::PAGE_TAG_W'(queue_rd_ff[TIW-1:0]);
               rsp_data_in.tag_present = 1'b1;
            end
         end
         default: begin
            has_rsp = 1'b0;
         end
      endcase

      // Hold the request in execute while its response cannot be registered.
      commit = (state_ff == S_EXEC) && (!has_rsp || !rsp_valid_ff || rsp_ch.ready);
      if (!commit) begin
         stack_we  = 1'b0;
         queue_we  = 1'b0;
         sdepth_in = sdepth_ff;
         qhead_in  = qhead_ff;
         qtail_in  = qtail_ff;
         qcount_in = qcount_ff;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (commit && has_rsp) begin
         rsp_valid_in = 1'b1;
      end

      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sdepth_ff    <= '0;
         qhead_ff     <= '0;
         qtail_ff     <= '0;
         qcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sdepth_ff    <= sdepth_in;
         qhead_ff     <= qhead_in;
         qtail_ff     <= qtail_in;
         qcount_ff    <= qcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (commit && has_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `HSQ_ASSERT_SAME(a_stack_bound, clock, reset, 1'b1, sdepth_ff <= SDW'(STACK_DEPTH))
   `HSQ_ASSERT_SAME(a_queue_bound, clock, reset, 1'b1, qcount_ff <= QCW'(QUEUE_DEPTH))
   `HSQ_ASSERT_NEXT(a_accept_exec, clock, reset, accept, state_ff == S_EXEC)
   `HSQ_ASSERT_NEXT(a_commit_idle, clock, reset, commit, state_ff == S_IDLE)
   `HSQ_ASSERT_SAME(a_tag_no_ovf, clock, reset, rsp_valid_ff && rsp_data_ff.tag_present,
                    !rsp_data_ff.overflow)

endmodule

FILE: dv/hsq_checker.sv
// Response scoreboard for the page history stack and its save queue.
module hsq_checker
   import hsq_pkg::*;
(
   input  logic clock,
   input  logic reset,
   hsq_req_if   req_mon,
   hsq_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   rsp_total,
   output int   overflow_total,
   output int   peak_depth,
   output int   peak_saved
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_SLOTS = 64;
   localparam int SAVE_SLOTS  = 64;

   logic [PAGE_TAG_W-1:0] page_stack [STACK_SLOTS];
   logic [COUNT_W-1:0]    page_depth;
   logic [PAGE_TAG_W-1:0] saved_tags [SAVE_SLOTS];
   logic [5:0]            save_head;
   logic [5:0]            save_tail;
   logic [COUNT_W-1:0]    save_count;

   rsp_type expected_rsps [$];

   int mismatches   = 0;
   int rsp_seen     = 0;
   int ovf_seen     = 0;
   int deepest      = 0;
   int fullest      = 0;

   // Apply one request to the shadow state; return 1 when it yields a response.
   function automatic bit predict_page_op(input req_type r, output rsp_type rsp);
      rsp = '0;
      predict_page_op = 1'b1;
      case (r.op)
         OP_OPEN: begin
            if (page_depth >= STACK_SLOTS) begin
               rsp.overflow = 1'b1;
            end else begin
               page_stack[page_depth] = r.page_tag;
               page_depth++;
            end
            rsp.count = page_depth;
         end
         OP_BACK: begin
            if (page_depth != 0) begin
               page_depth--;
               rsp.count = page_depth;
               if (page_depth != 0) begin
                  rsp.tag_out     = page_stack[page_depth - 1];
                  rsp.tag_present = 1'b1;
               end
            end
         end
         OP_CURSOR: begin
            if (page_depth != 0) begin
               rsp.count       = page_depth;
               rsp.tag_out     = page_stack[page_depth - 1];
               rsp.tag_present = 1'b1;
            end
         end
         OP_PANIC: begin
            rsp.count  = page_depth;
            page_depth = '0;
         end
         OP_SAVE: begin
            if (page_depth == 0) begin
               predict_page_op = 1'b0;
            end else if (save_count >= SAVE_SLOTS) begin
               rsp.overflow = 1'b1;
               rsp.count    = save_count;
            end else begin
               saved_tags[save_tail] = page_stack[page_depth - 1];
               save_tail++;
               save_count++;
               rsp.count = save_count;
            end
         end
         OP_READ: begin
            if (save_count != 0) begin
               rsp.tag_out     = saved_tags[save_head];
               rsp.tag_present = 1'b1;
               save_head++;
               save_count--;
               rsp.count = save_count;
            end
         end
         default: predict_page_op = 1'b0;
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      rsp_type fresh;
      if (reset) begin
         page_depth = '0;
         save_head  = '0;
         save_tail  = '0;
         save_count = '0;
         expected_rsps.delete();
      end else begin
         // Pop before push: a request never answers at its own acceptance edge.
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            rsp_seen++;
            if (got.overflow) ovf_seen++;
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: count %0d tag %h present %b overflow %b",
                           got.count, got.tag_out, got.tag_present, got.overflow);
            end else begin
               want = expected_rsps.pop_front();
               if (got.count !== want.count || got.tag_out !== want.tag_out ||
                   got.tag_present !== want.tag_present || got.overflow !== want.overflow) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("response %0d mismatch: expected count %0d tag %h present %b ovf %b",
                              rsp_seen, want.count, want.tag_out, want.tag_present,
                              want.overflow);
                     $display("   got count %0d tag %h present %b ovf %b",
                              got.count, got.tag_out, got.tag_present, got.overflow);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (predict_page_op(req_mon.payload, fresh)) expected_rsps.push_back(fresh);
            if (page_depth > deepest) deepest = page_depth;
            if (save_count > fullest) fullest = save_count;
         end
      end
      pending        <= expected_rsps.size();
      fail_count     <= mismatches;
      rsp_total      <= rsp_seen;
      overflow_total <= ovf_seen;
      peak_depth     <= deepest;
      peak_saved     <= fullest;
   end

endmodule

FILE: dv/tb_top.sv
// Testbench top: clock, reset, request stimulus and response back-pressure.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hsq_pkg::*;

   localparam int TARGET_ITEMS = 1800;
   localparam int IDLE_LIMIT   = 2000;

   // The two codes the block decodes to nothing.
   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

   typedef enum int {MIX_BALANCED, MIX_GROW, MIX_SAVE, MIX_SHRINK, MIX_NOISE} mix_type;

   logic clock;
   logic reset;
   bit   calm;
   int   sent;
   int   fail_count;
   int   pending;
   int   rsp_total;
   int   overflow_total;
   int   peak_depth;
   int   peak_saved;
   int unsigned hold;

   hsq_req_if req_ch ();
   hsq_rsp_if rsp_ch ();

   history_stack_with_save_queue dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   hsq_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .fail_count     (fail_count),
      .pending        (pending),
      .rsp_total      (rsp_total),
      .overflow_total (overflow_total),
      .peak_depth     (peak_depth),
      .peak_saved     (peak_saved)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Response side: after each accepted response, hold ready low until a random hold count runs out; none when calm.
   always @(posedge clock) begin
      int unsigned n;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold         <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         n = calm ? 0 : $urandom_range(0, 7);
         hold         <= n;
         rsp_ch.ready <= (n == 0);
      end else if (hold != 0) begin
         hold         <= hold - 1;
         rsp_ch.ready <= (hold == 1);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Watchdog: give up after a long stretch with no request or response accepted.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("no handshake for %0d cycles, %0d responses outstanding", IDLE_LIMIT, pending);
      $display("simulation failed");
      $finish;
   end

   task automatic send_page_op(input logic [OP_W-1:0] op, input logic [PAGE_TAG_W-1:0] tag);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= req_type'{op: op, page_tag: tag};
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (op <= OP_READ) sent++;
   endtask

   // Hold off new requests until every predicted response is back.
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [OP_W-1:0] pick_op(input mix_type mix);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_GROW: begin
            if (roll < 80) return OP_OPEN;
            if (roll < 85) return OP_BACK;
            if (roll < 90) return OP_CURSOR;
            return OP_SAVE;
         end
         MIX_SAVE: begin
            if (roll < 75) return OP_SAVE;
            if (roll < 85) return OP_OPEN;
            if (roll < 90) return OP_CURSOR;
            return OP_READ;
         end
         MIX_SHRINK: begin
            if (roll < 35) return OP_BACK;
            if (roll < 75) return OP_READ;
            if (roll < 80) return OP_PANIC;
            if (roll < 90) return OP_CURSOR;
            return OP_OPEN;
         end
         MIX_NOISE: begin
            if (roll < 15) return OP_SPARE_A;
            if (roll < 30) return OP_SPARE_B;
            if (roll < 50) return OP_OPEN;
            if (roll < 60) return OP_BACK;
            if (roll < 80) return OP_SAVE;
            if (roll < 90) return OP_READ;
            if (roll < 95) return OP_CURSOR;
            return OP_PANIC;
         end
         default: begin
            if (roll < 25) return OP_OPEN;
            if (roll < 40) return OP_BACK;
            if (roll < 55) return OP_CURSOR;
            if (roll < 60) return OP_PANIC;
            if (roll < 80) return OP_SAVE;
            return OP_READ;
         end
      endcase
   endfunction

   initial begin
      mix_type mix;
      int      phase_len;
      sent = 0;
      calm = 1'b0;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Empty-store corner cases, unused codes, then small push/save/read walks.
      send_page_op(OP_CURSOR, $urandom());
      send_page_op(OP_BACK, $urandom());
      send_page_op(OP_READ, $urandom());
      send_page_op(OP_SAVE, $urandom());
      send_page_op(OP_PANIC, $urandom());
      send_page_op(OP_SPARE_A, $urandom());
      send_page_op(OP_SPARE_B, $urandom());
      send_page_op(OP_OPEN, '0);
      send_page_op(OP_OPEN, '1);
      send_page_op(OP_CURSOR, '0);
      send_page_op(OP_SAVE, '1);
      send_page_op(OP_SAVE, $urandom());
      send_page_op(OP_BACK, $urandom());
      send_page_op(OP_SAVE, $urandom());
      send_page_op(OP_BACK, $urandom());
      send_page_op(OP_OPEN, 32'ha5a5_a5a5);
      send_page_op(OP_OPEN, 32'h5a5a_5a5a);
      send_page_op(OP_READ, '1);
      send_page_op(OP_READ, $urandom());
      send_page_op(OP_READ, $urandom());
      send_page_op(OP_READ, $urandom());
      send_page_op(OP_READ, $urandom());
      send_page_op(OP_PANIC, $urandom());
      drain_responses();

      // Random phases, each balanced or biased toward filling, saving, draining or noise.
      while (sent < TARGET_ITEMS) begin
         mix       = mix_type'($urandom_range(0, 4));
         phase_len = $urandom_range(40, 120);
         calm     <= ($urandom_range(0, 4) == 0);
         repeat (phase_len) send_page_op(pick_op(mix), $urandom());
         if ($urandom_range(0, 3) == 0) drain_responses();
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d requests sent, %0d responses checked, %0d of them flagged overflow",
               sent, rsp_total, overflow_total);
      $display("deepest history stack %0d, fullest save queue %0d", peak_depth, peak_saved);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d responses wrong or unexpected", fail_count);
         $display("simulation failed");
      end
      $finish;
   end

endmodule
